// File: rtl/core/countdown_timer_bank_unit_macros.svh
// Assertion macros for the countdown timer bank.
`ifndef COUNTDOWN_TIMER_BANK_UNIT_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_UNIT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define CTB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define CTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ctb_pkg.sv
// Shared types and constants for the countdown timer bank.
`default_nettype none
package ctb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int DATA_W     = 32;

	// in-use count saturates at the bank size (also the index reach)
	localparam logic [CNT_W-1:0] MAX_IN_USE = CNT_W'(NUM_TIMERS);

	typedef enum logic [1:0] {
		CMD_TICK_ALL = 2'd0,
		CMD_SET      = 2'd1,
		CMD_CANCEL   = 2'd2,
		CMD_TICK_ONE = 2'd3
	} cmd_e;

	typedef struct packed {
		logic accept;
		logic exec;
		logic report;
		logic bad;
		cmd_e op;
	} ctl_t;

	typedef struct packed {
		logic idx_bad;
		logic n_zero;
		logic last_slot;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/ctb_ctrl.sv
// Controller state machine of the countdown timer bank.
`default_nettype none
module ctb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        cmd,
	input  wire ctb_pkg::dp_stat_t stat,
	output logic                   busy,
	output ctb_pkg::ctl_t          ctl
);
	import ctb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_REPORT = 3'b100
	} state_t;

	state_t state_q;
	cmd_e   op_q;
	logic   bad_q;
	logic   accept;
	cmd_e   cmd_in;
	logic   in_bad;

	assign cmd_in = cmd_e'(cmd);
	assign accept = start && (state_q == S_IDLE);
	assign in_bad = (cmd_in != CMD_TICK_ALL) && stat.idx_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= CMD_TICK_ALL;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= cmd_in;
						bad_q <= in_bad;
						if (in_bad || ((cmd_in == CMD_TICK_ALL) && stat.n_zero)) begin
							state_q <= S_REPORT;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if ((op_q != CMD_TICK_ALL) || stat.last_slot) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign ctl.accept = accept;
	assign ctl.exec   = (state_q == S_EXEC);
	assign ctl.report = (state_q == S_REPORT);
	assign ctl.bad    = bad_q;
	assign ctl.op     = op_q;

endmodule
`default_nettype wire

// File: rtl/core/ctb_datapath.sv
// Timer storage, shared decrementer and result register.
`default_nettype none
module ctb_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ctb_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire logic [1:0]                  cmd,
	input  wire logic [ctb_pkg::IDX_W-1:0]   timer_index,
	input  wire logic [ctb_pkg::DATA_W-1:0]  delta,
	input  wire ctb_pkg::ctl_t               ctl,
	output ctb_pkg::dp_stat_t                stat,
	output logic                             result_strobe,
	output logic                             fired,
	output logic [ctb_pkg::IDX_W-1:0]        expired_index,
	output logic                             bad_index,
	output logic                             last
);
	import ctb_pkg::*;

	logic [CNT_W-1:0]  in_use_q;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  n_m1;
	logic [IDX_W-1:0]  ptr_q;
	logic [DATA_W-1:0] delta_q;
	logic [DATA_W-1:0] count_q [NUM_TIMERS];
	logic              armed_q [NUM_TIMERS];
	logic [DATA_W-1:0] dec;
	logic              is_tick;
	logic              hit;
	logic              held_v_q;
	logic [IDX_W-1:0]  held_idx_q;
	logic              strobe_q;

	assign n_eff = (in_use_q > MAX_IN_USE) ? MAX_IN_USE : in_use_q;
	assign n_m1  = n_eff - CNT_W'(1);

	assign stat.idx_bad   = ({1'b0, timer_index} >= n_eff);
	assign stat.n_zero    = (n_eff == '0);
	assign stat.last_slot = (ptr_q == n_m1[IDX_W-1:0]);

	// one shared decrementer, addressed by the sweep pointer
	assign dec     = count_q[ptr_q] - DATA_W'(1);
	assign is_tick = (ctl.op == CMD_TICK_ALL) || (ctl.op == CMD_TICK_ONE);
	assign hit     = ctl.exec && is_tick && armed_q[ptr_q] && (dec == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cfg_we) begin
			in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			ptr_q   <= (cmd_e'(cmd) == CMD_TICK_ALL) ? '0 : timer_index;
			delta_q <= delta;
		end else if (ctl.exec) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			unique case (ctl.op) inside
				CMD_SET: begin
					count_q[ptr_q] <= delta_q;
				end
				CMD_TICK_ALL, CMD_TICK_ONE: begin
					if (armed_q[ptr_q]) begin
						count_q[ptr_q] <= dec;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				armed_q[i] <= 1'b0;
			end
		end else if (ctl.exec) begin
			unique case (ctl.op) inside
				CMD_SET: begin
					armed_q[ptr_q] <= 1'b1;
				end
				CMD_CANCEL: begin
					armed_q[ptr_q] <= 1'b0;
				end
				CMD_TICK_ALL, CMD_TICK_ONE: begin
					if (hit) begin
						armed_q[ptr_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// one expiry held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (ctl.accept) begin
			held_v_q <= 1'b0;
		end else if (hit) begin
			held_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			held_idx_q <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (hit && held_v_q) || ctl.report;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.report) begin
			fired         <= held_v_q;
			expired_index <= held_v_q ? held_idx_q : '0;
			bad_index     <= held_v_q ? 1'b0 : ctl.bad;
			last          <= 1'b1;
		end else if (hit && held_v_q) begin
			fired         <= 1'b1;
			expired_index <= held_idx_q;
			bad_index     <= 1'b0;
			last          <= 1'b0;
		end
	end

	assign result_strobe = strobe_q;

endmodule
`default_nettype wire

// File: rtl/core/countdown_timer_bank_unit.sv
// Top level of the countdown timer bank: controller plus datapath.
// Set, cancel and tick one hold busy through exec and report; a bad index or tick all
//   with no timers in use goes straight to report; tick all first sweeps those in use.
// Throughput: one timer per cycle through the single shared decrementer, one result per
//   cycle; the last result of a transaction shows in the cycle busy falls.
// Reset (arst_n low) clears armed bits, the in-use count, the state and the result strobe.
// The receiver cannot stall: result_strobe marks each result for exactly one cycle.
`default_nettype none
`include "countdown_timer_bank_unit_macros.svh"
module countdown_timer_bank_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: in-use count
	input  wire logic                        cfg_we,
	input  wire logic [ctb_pkg::CNT_W-1:0]   cfg_wdata,
	// command transaction
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  cmd,
	input  wire logic [ctb_pkg::IDX_W-1:0]   timer_index,
	input  wire logic [ctb_pkg::DATA_W-1:0]  delta,
	// result transaction
	output logic                             result_strobe,
	output logic                             fired,
	output logic [ctb_pkg::IDX_W-1:0]        expired_index,
	output logic                             bad_index,
	output logic                             last
);
	import ctb_pkg::*;

	// command bundle from controller, status bundle from datapath
	ctl_t     ctl;
	dp_stat_t stat;

	// The controller sequences a transaction: accept in idle, exec for each timer visited
	// (sweep for tick all, a single slot otherwise), then report; exec is skipped on a bad index or with no timers in use.
	ctb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// The datapath holds counts and armed bits, decrements the addressed timer and
	// holds one expiry back so that only the final result carries last.
	ctb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.timer_index   (timer_index),
		.delta         (delta),
		.ctl           (ctl),
		.stat          (stat),
		.result_strobe (result_strobe),
		.fired         (fired),
		.expired_index (expired_index),
		.bad_index     (bad_index),
		.last          (last)
	);

	// exec and report cycles never overlap
	`CTB_ASSERT_IMPL(a_exec_report_excl, clk, arst_n, ctl.exec, !ctl.report, "exec during report")
	// a report cycle always yields a final result next cycle
	`CTB_ASSERT_NEXT(a_report_last, clk, arst_n, ctl.report, result_strobe && last, "no final result")
	// an expiry result never carries the bad index flag
	`CTB_ASSERT_IMPL(a_fired_not_bad, clk, arst_n, result_strobe && fired, !bad_index, "fired and bad")
	// once a transaction is taken, the unit reports busy
	`CTB_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept without busy")

endmodule
`default_nettype wire
